[sv/sort_reduce_by_key_mod_assert.svh]
// Assertion macros for the sorted reduce-by-key block.
// SRKM_ASSERT_IMPL: same-cycle implication, SRKM_ASSERT_NEXT: next-cycle implication.
`ifndef SORT_REDUCE_BY_KEY_MOD_ASSERT_SVH
`define SORT_REDUCE_BY_KEY_MOD_ASSERT_SVH
`ifndef SYNTHESIS
`define SRKM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srkm assertion failed");
`define SRKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srkm assertion failed");
`else
`define SRKM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SRKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/srkm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package srkm_pkg;

    localparam int KEY_W     = 64;
    localparam int VAL_W     = 31;
    localparam int ENTRY_W   = 2 * KEY_W + VAL_W;
    localparam int DEPTH_DEF = 64;

    localparam logic [VAL_W-1:0] MODULUS = 31'h7FFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic load_rec;
        logic idx_clr;
        logic idx_inc;
        logic rd_idx;
        logic write_sum;
        logic set_ovf;
        logic j_load;
        logic rd_shift;
        logic wr_shift;
        logic wr_new;
        logic out_load;
        logic batch_clr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic search_end;
        logic key_lt;
        logic key_eq;
        logic full;
        logic shift_done;
        logic rec_last;
        logic empty;
        logic out_taken;
        logic out_last;
    } t_status;

    function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

[sv/srkm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module srkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/srkm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module srkm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire srkm_pkg::t_status i_status,
    output srkm_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_NOMATCH,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_CLOSE,
        S_OUT_RD,
        S_OUT_LOAD,
        S_OUT_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    srkm_pkg::t_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_rec = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    n_state      = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_status.search_end) begin
                    n_state = S_NOMATCH;
                end else begin
                    cmd.rd_idx = 1'b1;
                    n_state    = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_status.key_lt) begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_SRCH_RD;
                end else if (i_status.key_eq) begin
                    cmd.write_sum = 1'b1;
                    n_state       = S_CLOSE;
                end else begin
                    n_state = S_NOMATCH;
                end
            end
            S_NOMATCH: begin
                // full store: drop the request, remember it
                if (i_status.full) begin
                    cmd.set_ovf = 1'b1;
                    n_state     = S_CLOSE;
                end else begin
                    cmd.j_load = 1'b1;
                    n_state    = S_SHIFT_CHK;
                end
            end
            S_SHIFT_CHK: begin
                if (i_status.shift_done) begin
                    cmd.wr_new = 1'b1;
                    n_state    = S_CLOSE;
                end else begin
                    cmd.rd_shift = 1'b1;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                n_state      = S_SHIFT_CHK;
            end
            S_CLOSE: begin
                if (!i_status.rec_last) begin
                    n_state = S_IDLE;
                end else if (i_status.empty) begin
                    cmd.batch_clr = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.idx_clr = 1'b1;
                    n_state     = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                cmd.rd_idx = 1'b1;
                n_state    = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                cmd.out_load = 1'b1;
                n_state      = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_status.out_taken) begin
                    if (i_status.out_last) begin
                        cmd.batch_clr = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        n_state     = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = i_rst_n ? cmd : '0;
    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

endmodule
`default_nettype wire

[sv/srkm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module srkm_dp #(
    parameter int DEPTH = srkm_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srkm_pkg::t_cmd                i_cmd,
    output srkm_pkg::t_status                  o_status,
    input  wire logic [srkm_pkg::KEY_W-1:0]    i_key_high,
    input  wire logic [srkm_pkg::KEY_W-1:0]    i_key_low,
    input  wire logic [srkm_pkg::VAL_W-1:0]    i_value,
    input  wire logic                          i_last_record,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic      [srkm_pkg::KEY_W-1:0]    o_group_key_high,
    output logic      [srkm_pkg::KEY_W-1:0]    o_group_key_low,
    output logic      [srkm_pkg::VAL_W-1:0]    o_group_sum,
    output logic                               o_last_group,
    output logic                               o_overflowed
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = srkm_pkg::KEY_W;
    localparam int VW = srkm_pkg::VAL_W;
    localparam int EW = srkm_pkg::ENTRY_W;

    logic [KW-1:0] r_kh;
    logic [KW-1:0] r_kl;
    logic [VW-1:0] r_v;
    logic          r_last;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_count;
    logic          r_ovf;

    logic          r_out_valid;
    logic [KW-1:0] r_out_kh;
    logic [KW-1:0] r_out_kl;
    logic [VW-1:0] r_out_sum;
    logic          r_out_last;
    logic          r_out_ovf;

    logic [EW-1:0] rd_data;
    logic [KW-1:0] rd_kh;
    logic [KW-1:0] rd_kl;
    logic [VW-1:0] rd_sum;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [CW-1:0] j_dec;
    logic [CW-1:0] idx_inc;
    logic          out_taken;

    assign rd_kh  = rd_data[EW-1 -: KW];
    assign rd_kl  = rd_data[VW +: KW];
    assign rd_sum = rd_data[VW-1:0];

    assign j_dec     = r_j - CW'(1);
    assign idx_inc   = r_idx + CW'(1);
    assign out_taken = r_out_valid && !i_stall;

    always_comb begin
        ram_re    = i_cmd.rd_idx || i_cmd.rd_shift;
        ram_raddr = i_cmd.rd_shift ? j_dec[AW-1:0] : r_idx[AW-1:0];
        ram_we    = i_cmd.write_sum || i_cmd.wr_shift || i_cmd.wr_new;
        ram_waddr = i_cmd.wr_shift ? r_j[AW-1:0] : r_idx[AW-1:0];
        if (i_cmd.wr_shift) begin
            ram_wdata = rd_data;
        end else if (i_cmd.write_sum) begin
            ram_wdata = {r_kh, r_kl, srkm_pkg::add_mod(rd_sum, r_v)};
        end else begin
            ram_wdata = {r_kh, r_kl, r_v};
        end
    end

    srkm_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd_data)
    );

    // record and pointer registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rec) begin
            r_kh   <= i_key_high;
            r_kl   <= i_key_low;
            // the modulus itself counts as zero
            r_v    <= (i_value == srkm_pkg::MODULUS) ? '0 : i_value;
            r_last <= i_last_record;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_inc;
        end
        if (i_cmd.j_load) begin
            r_j <= r_count;
        end else if (i_cmd.wr_shift) begin
            r_j <= j_dec;
        end
        if (i_cmd.out_load) begin
            r_out_kh   <= rd_kh;
            r_out_kl   <= rd_kl;
            r_out_sum  <= rd_sum;
            r_out_last <= (idx_inc == r_count);
            r_out_ovf  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.batch_clr) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (i_cmd.wr_new) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.set_ovf) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.search_end = (r_idx == r_count);
    assign o_status.key_lt     = ({rd_kh, rd_kl} < {r_kh, r_kl});
    assign o_status.key_eq     = ({rd_kh, rd_kl} == {r_kh, r_kl});
    assign o_status.full       = (r_count == CW'(DEPTH));
    assign o_status.shift_done = (r_j == r_idx);
    assign o_status.rec_last   = r_last;
    assign o_status.empty      = (r_count == '0);
    assign o_status.out_taken  = out_taken;
    assign o_status.out_last   = r_out_last;

    assign o_valid          = r_out_valid;
    assign o_group_key_high = r_out_kh;
    assign o_group_key_low  = r_out_kl;
    assign o_group_sum      = r_out_sum;
    assign o_last_group     = r_out_last;
    assign o_overflowed     = r_out_ovf;

endmodule
`default_nettype wire

[sv/sort_reduce_by_key_mod.sv]
// Sorted reduce-by-key with a sum modulo 2^31-1.
// Input channel: i_valid / o_stall carry one record (128-bit key as high and low
// halves, a 31-bit value, and i_last_record). A record is taken when i_valid is
// high and o_stall is low. The block keeps up to DEPTH distinct keys in a sorted
// single-port-write RAM and adds values of equal keys modulo 2^31-1.
// Per record: a linear search reads the stored entries one at a time, then a
// new key shifts the larger entries up by one. o_stall stays high after a
// record is taken until the block is done with it (on the last record, until
// all results are out), so records are taken one at a time.
// Output channel: o_valid / i_stall. On the record flagged last, the block
// emits one result per group in ascending unsigned key order. o_last_group
// marks the final result; o_overflowed is set on every result of a batch in
// which a new key met a full store and was dropped. A stalled result holds
// until taken, and the next is fetched only then. After the final result the
// store and overflow flag are cleared.
// Reset (i_rst_n low, synchronous) empties the store and flag at once; no
// clearing pass is needed, and o_stall is high while reset is asserted.
`timescale 1ns / 1ps
`default_nettype none
module sort_reduce_by_key_mod #(
    parameter int DEPTH = srkm_pkg::DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [srkm_pkg::KEY_W-1:0] i_key_high,
    input  wire logic [srkm_pkg::KEY_W-1:0] i_key_low,
    input  wire logic [srkm_pkg::VAL_W-1:0] i_value,
    input  wire logic                       i_last_record,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic      [srkm_pkg::KEY_W-1:0] o_group_key_high,
    output logic      [srkm_pkg::KEY_W-1:0] o_group_key_low,
    output logic      [srkm_pkg::VAL_W-1:0] o_group_sum,
    output logic                            o_last_group,
    output logic                            o_overflowed
);

    srkm_pkg::t_cmd    cmd;
    srkm_pkg::t_status status;

    srkm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_status(status),
        .o_cmd   (cmd)
    );

    srkm_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_key_high      (i_key_high),
        .i_key_low       (i_key_low),
        .i_value         (i_value),
        .i_last_record   (i_last_record),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_group_key_high(o_group_key_high),
        .o_group_key_low (o_group_key_low),
        .o_group_sum     (o_group_sum),
        .o_last_group    (o_last_group),
        .o_overflowed    (o_overflowed)
    );

`include "sort_reduce_by_key_mod_assert.svh"

    `SRKM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `SRKM_ASSERT_IMPL(a_no_accept_while_out, i_clk, i_rst_n, o_valid, o_stall)
    `SRKM_ASSERT_NEXT(a_batch_ends, i_clk, i_rst_n, o_valid && !i_stall && o_last_group, !o_valid)
    `SRKM_ASSERT_NEXT(a_store_cleared, i_clk, i_rst_n, o_valid && !i_stall && o_last_group, status.empty)

endmodule
`default_nettype wire
